>>> rtl/core/bmes_pkg.sv
package bmes_pkg;

	// Number of CORDIC micro-rotations per sine/cosine evaluation (8 to 30).
	localparam int CORDIC_STAGES = 16;

	// Register stages through one sine/cosine unit: angle product, pre-rotation,
	// the micro-rotations and the output sign fix.
	localparam int SC_LAT = CORDIC_STAGES + 3;

	// Quotient bits of the tangent divider, one per stage.
	localparam int DIV_STEPS = 31;

	localparam int ADDR_W = 4;
	localparam int CFG_W  = 31;

	localparam logic signed [31:0] Q_MAX      = 32'sh7FFF_FFFF;
	localparam logic signed [31:0] Q_MIN      = 32'sh8000_0000;
	localparam logic signed [31:0] RAD_TO_BAM = 32'sd683565276;
	localparam logic signed [33:0] CORDIC_GAIN = 34'sd652032875;

	localparam logic [CFG_W-1:0] TIME_STEP_RST       = 31'd6554;
	localparam logic [CFG_W-1:0] HALF_WHEEL_BASE_RST = 31'd81920;
	localparam logic [CFG_W-1:0] INV_WHEEL_BASE_RST  = 31'd26214;

	typedef enum logic [1:0] {
		REG_TIME_STEP       = 2'd0,
		REG_HALF_WHEEL_BASE = 2'd1,
		REG_INV_WHEEL_BASE  = 2'd2
	} reg_idx_t;

	// Clamp a wide signed value to the signed 32-bit range.
	function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
		logic signed [31:0] r;
		if (v > 64'(Q_MAX)) begin
			r = Q_MAX;
		end else if (v < 64'(Q_MIN)) begin
			r = Q_MIN;
		end else begin
			r = v[31:0];
		end
		return r;
	endfunction

	// Round half up a product with f fraction bits, then saturate.
	function automatic logic signed [31:0] qround(input logic signed [63:0] p, input int f);
		logic signed [63:0] t;
		t = (p + (64'sd1 <<< (f - 1))) >>> f;
		return sat32(t);
	endfunction

	// Arctangent of 2^-i as a binary angle, a full turn being 2^32.
	function automatic logic signed [33:0] atan_bam(input int i);
		logic signed [33:0] r;
		case (i)
			0:  r = 34'sh20000000;
			1:  r = 34'sh12E4051E;
			2:  r = 34'sh09FB385B;
			3:  r = 34'sh051111D4;
			4:  r = 34'sh028B0D43;
			5:  r = 34'sh0145D7E1;
			6:  r = 34'sh00A2F61E;
			7:  r = 34'sh00517C55;
			8:  r = 34'sh0028BE53;
			9:  r = 34'sh00145F2F;
			10: r = 34'sh000A2F98;
			11: r = 34'sh000517CC;
			12: r = 34'sh00028BE6;
			13: r = 34'sh000145F3;
			14: r = 34'sh0000A2F9;
			15: r = 34'sh0000517C;
			16: r = 34'sh000028BE;
			17: r = 34'sh0000145F;
			18: r = 34'sh00000A2F;
			19: r = 34'sh00000517;
			20: r = 34'sh0000028B;
			21: r = 34'sh00000145;
			22: r = 34'sh000000A2;
			23: r = 34'sh00000051;
			24: r = 34'sh00000028;
			25: r = 34'sh00000014;
			26: r = 34'sh0000000A;
			27: r = 34'sh00000005;
			28: r = 34'sh00000002;
			29: r = 34'sh00000001;
			default: r = 34'sh0;
		endcase
		return r;
	endfunction

endpackage

>>> rtl/core/bmes_state_if.sv
interface bmes_state_if;
	logic               valid;
	logic               ready;
	logic signed [31:0] pos_x;
	logic signed [31:0] pos_y;
	logic signed [31:0] steer_angle;
	logic signed [31:0] speed;
	logic signed [31:0] heading;
	logic signed [31:0] steer_rate;
	logic signed [31:0] accel;

	modport source (output valid, pos_x, pos_y, steer_angle, speed, heading, steer_rate, accel,
		input ready);
	modport sink (input valid, pos_x, pos_y, steer_angle, speed, heading, steer_rate, accel,
		output ready);
endinterface

>>> rtl/core/bmes_next_if.sv
interface bmes_next_if;
	logic               valid;
	logic               ready;
	logic signed [31:0] next_pos_x;
	logic signed [31:0] next_pos_y;
	logic signed [31:0] next_steer_angle;
	logic signed [31:0] next_speed;
	logic signed [31:0] next_heading;

	modport source (output valid, next_pos_x, next_pos_y, next_steer_angle, next_speed,
		next_heading, input ready);
	modport sink (input valid, next_pos_x, next_pos_y, next_steer_angle, next_speed,
		next_heading, output ready);
endinterface

>>> rtl/core/bmes_sincos.sv
// Pipelined rotation-mode CORDIC: sine and cosine in Q2.30 of a Q16.16 radian angle.
module bmes_sincos (
	input  logic               clk,
	input  logic               en,
	input  logic signed [31:0] rad,
	output logic signed [31:0] sin_val,
	output logic signed [31:0] cos_val
);
	localparam int N = bmes_pkg::CORDIC_STAGES;

	logic signed [63:0] prod_s1;
	logic signed [33:0] x_s [0:N];
	logic signed [33:0] y_s [0:N];
	logic signed [33:0] z_s [0:N];
	logic               neg_s [0:N];

	logic [63:0]        bam;
	logic signed [33:0] z_pre;
	logic               neg_pre;

	// Round to a binary angle, then fold the left half plane onto the right.
	always_comb begin
		bam     = prod_s1 + 64'sh8000;
		z_pre   = 34'($signed(bam[47:16]));
		neg_pre = 1'b0;
		if (z_pre > 34'sh4000_0000) begin
			z_pre   = z_pre - 34'sh8000_0000;
			neg_pre = 1'b1;
		end else if (z_pre < -34'sh4000_0000) begin
			z_pre   = z_pre + 34'sh8000_0000;
			neg_pre = 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			prod_s1  <= 64'(rad) * 64'(bmes_pkg::RAD_TO_BAM);
			x_s[0]   <= bmes_pkg::CORDIC_GAIN;
			y_s[0]   <= '0;
			z_s[0]   <= z_pre;
			neg_s[0] <= neg_pre;
			for (int i = 0; i < N; i++) begin
				if (z_s[i] >= 0) begin
					x_s[i+1] <= x_s[i] - (y_s[i] >>> i);
					y_s[i+1] <= y_s[i] + (x_s[i] >>> i);
					z_s[i+1] <= z_s[i] - bmes_pkg::atan_bam(i);
				end else begin
					x_s[i+1] <= x_s[i] + (y_s[i] >>> i);
					y_s[i+1] <= y_s[i] - (x_s[i] >>> i);
					z_s[i+1] <= z_s[i] + bmes_pkg::atan_bam(i);
				end
				neg_s[i+1] <= neg_s[i];
			end
			cos_val <= neg_s[N] ? 32'(-x_s[N]) : x_s[N][31:0];
			sin_val <= neg_s[N] ? 32'(-y_s[N]) : y_s[N][31:0];
		end
	end
endmodule

>>> rtl/core/bicycle_model_euler_step.sv
// One forward-Euler step of the kinematic bicycle model in signed Q16.16.
// A state word (center position, steering angle, speed, heading, steering
// rate, acceleration) enters on state_in; the next state leaves on state_out,
// one word out for every word in, in order. Both channels are valid/ready.
// The APB port holds time_step, half_wheel_base and inv_wheel_base at byte
// addresses 0, 4 and 8; write them only while no word is in flight.
// Each word passes through two sine/cosine units in series, the 31-stage
// tangent divider and the multiply, round and sum stages around them.
// Throughput is one word per cycle unless a full output register is held.
// All stages advance together whenever the output register is empty or
// being taken, so a stalled receiver freezes the whole pipeline and
// state_in.ready drops in the same cycle; nothing is lost or repeated.
// Reset clears the valid bits and loads the default registers.
module bicycle_model_euler_step (
	input  logic                        clk,
	input  logic                        arst_n,
	bmes_state_if.sink                  state_in,
	bmes_next_if.source                 state_out,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [bmes_pkg::ADDR_W-1:0] paddr,
	input  logic [31:0]                 pwdata,
	output logic [31:0]                 prdata,
	output logic                        pready
);
	localparam int L       = bmes_pkg::SC_LAT;
	localparam int T_DPREP = L + 1;
	localparam int T_TAN   = L + bmes_pkg::DIV_STEPS + 2;
	localparam int T_XR    = L + 2;
	localparam int T_XRN   = L + 3;
	localparam int T_THN   = T_TAN + 4;
	localparam int T_FP    = T_THN + L + 1;
	localparam int T_OUT   = T_THN + L + 2;

	typedef struct packed {
		logic szero;
		logic czero;
		logic sat;
		logic neg;
		logic ssign;
	} div_flag_t;

	// Configuration registers.
	logic [bmes_pkg::CFG_W-1:0] ts_q, hwb_q, iwb_q;
	logic signed [31:0]         ts_sx, hwb_sx, iwb_sx;
	bmes_pkg::reg_idx_t         ridx;

	assign pready = 1'b1;
	assign ridx   = bmes_pkg::reg_idx_t'(paddr[3:2]);
	assign ts_sx  = {1'b0, ts_q};
	assign hwb_sx = {1'b0, hwb_q};
	assign iwb_sx = {1'b0, iwb_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ts_q  <= bmes_pkg::TIME_STEP_RST;
			hwb_q <= bmes_pkg::HALF_WHEEL_BASE_RST;
			iwb_q <= bmes_pkg::INV_WHEEL_BASE_RST;
		end else if (psel && penable && pwrite) begin
			unique case (ridx)
				bmes_pkg::REG_TIME_STEP:       ts_q  <= pwdata[30:0];
				bmes_pkg::REG_HALF_WHEEL_BASE: hwb_q <= pwdata[30:0];
				bmes_pkg::REG_INV_WHEEL_BASE:  iwb_q <= pwdata[30:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (ridx)
			bmes_pkg::REG_TIME_STEP:       prdata = {1'b0, ts_q};
			bmes_pkg::REG_HALF_WHEEL_BASE: prdata = {1'b0, hwb_q};
			bmes_pkg::REG_INV_WHEEL_BASE:  prdata = {1'b0, iwb_q};
			default:                       prdata = '0;
		endcase
	end

	// Pipeline control: one enable for every stage.
	logic [T_OUT:1] vld_s;
	logic           en;

	assign en             = !vld_s[T_OUT] || state_out.ready;
	assign state_in.ready = en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s <= '0;
		end else if (en) begin
			vld_s <= {vld_s[T_OUT-1:1], state_in.valid};
		end
	end

	// Sine and cosine of the heading and of the steering angle, and later of
	// the new heading.
	logic signed [31:0] sin_th, cos_th, sin_dl, cos_dl, sin_tn, cos_tn;
	logic signed [31:0] thn_s [T_THN:T_OUT];

	bmes_sincos u_sc_head (.clk(clk), .en(en), .rad(state_in.heading),
		.sin_val(sin_th), .cos_val(cos_th));
	bmes_sincos u_sc_steer (.clk(clk), .en(en), .rad(state_in.steer_angle),
		.sin_val(sin_dl), .cos_val(cos_dl));
	bmes_sincos u_sc_next (.clk(clk), .en(en), .rad(thn_s[T_THN]),
		.sin_val(sin_tn), .cos_val(cos_tn));

	// Front: the products that need only the input word and the registers.
	logic signed [63:0] dvp_s1, dnp_s1, vnp_s1, vip_s1;
	logic signed [31:0] delta_s1, v_s1;
	logic signed [31:0] x_s [1:L+1];
	logic signed [31:0] y_s [1:L+1];
	logic signed [31:0] th_s [1:T_THN-1];
	logic signed [31:0] dv_s [2:L];
	logic signed [31:0] dn_s [2:T_OUT];
	logic signed [31:0] vn_s [2:T_OUT];
	logic signed [31:0] vi_s [2:T_TAN];

	always_ff @(posedge clk) begin
		if (en) begin
			dvp_s1   <= 64'(ts_sx) * 64'(state_in.speed);
			dnp_s1   <= 64'(ts_sx) * 64'(state_in.steer_rate);
			vnp_s1   <= 64'(ts_sx) * 64'(state_in.accel);
			vip_s1   <= 64'(state_in.speed) * 64'(iwb_sx);
			delta_s1 <= state_in.steer_angle;
			v_s1     <= state_in.speed;
			x_s[1]   <= state_in.pos_x;
			y_s[1]   <= state_in.pos_y;
			th_s[1]  <= state_in.heading;

			dv_s[2] <= bmes_pkg::qround(dvp_s1, 16);
			dn_s[2] <= bmes_pkg::sat32(64'(delta_s1) + 64'(bmes_pkg::qround(dnp_s1, 16)));
			vn_s[2] <= bmes_pkg::sat32(64'(v_s1) + 64'(bmes_pkg::qround(vnp_s1, 16)));
			vi_s[2] <= bmes_pkg::qround(vip_s1, 16);

			for (int k = 2; k <= L + 1; k++) begin
				x_s[k] <= x_s[k-1];
				y_s[k] <= y_s[k-1];
			end
			for (int k = 2; k <= T_THN - 1; k++) begin
				th_s[k] <= th_s[k-1];
			end
			for (int k = 3; k <= L; k++) begin
				dv_s[k] <= dv_s[k-1];
			end
			for (int k = 3; k <= T_OUT; k++) begin
				dn_s[k] <= dn_s[k-1];
				vn_s[k] <= vn_s[k-1];
			end
			for (int k = 3; k <= T_TAN; k++) begin
				vi_s[k] <= vi_s[k-1];
			end
		end
	end

	// Rear axle position and its advance along the old heading.
	logic signed [63:0] pc_s, ps_s, dc_s, ds_s;
	logic signed [31:0] xr_s, yr_s, dcq_s, dsq_s;
	logic signed [31:0] xrn_s [T_XRN:T_FP];
	logic signed [31:0] yrn_s [T_XRN:T_FP];

	always_ff @(posedge clk) begin
		if (en) begin
			pc_s <= 64'(hwb_sx) * 64'(cos_th);
			ps_s <= 64'(hwb_sx) * 64'(sin_th);
			dc_s <= 64'(dv_s[L]) * 64'(cos_th);
			ds_s <= 64'(dv_s[L]) * 64'(sin_th);

			xr_s  <= bmes_pkg::sat32(64'(x_s[L+1]) - 64'(bmes_pkg::qround(pc_s, 30)));
			yr_s  <= bmes_pkg::sat32(64'(y_s[L+1]) - 64'(bmes_pkg::qround(ps_s, 30)));
			dcq_s <= bmes_pkg::qround(dc_s, 30);
			dsq_s <= bmes_pkg::qround(ds_s, 30);

			xrn_s[T_XRN] <= bmes_pkg::sat32(64'(xr_s) + 64'(dcq_s));
			yrn_s[T_XRN] <= bmes_pkg::sat32(64'(yr_s) + 64'(dsq_s));
			for (int k = T_XRN + 1; k <= T_FP; k++) begin
				xrn_s[k] <= xrn_s[k-1];
				yrn_s[k] <= yrn_s[k-1];
			end
		end
	end

	// Tangent of the steering angle: restoring division of |sin| * 2^16 by
	// |cos|, one quotient bit per stage. The result saturates when the
	// quotient would reach 2^31, which is known up front from the operands:
	// that happens exactly when |sin| is at least |cos| * 2^15.
	logic [31:0]        dr_s [T_DPREP:T_TAN-1];
	logic [30:0]        dq_s [T_DPREP:T_TAN-1];
	logic [31:0]        dd_s [T_DPREP:T_TAN-1];
	div_flag_t          df_s [T_DPREP:T_TAN-1];
	logic signed [31:0] tan_s;
	logic [31:0]        as_c, ac_c;
	logic [31:0]        tq_c;

	assign as_c = sin_dl[31] ? 32'(-sin_dl) : sin_dl;
	assign ac_c = cos_dl[31] ? 32'(-cos_dl) : cos_dl;

	always_comb begin
		if (df_s[T_TAN-1].sat) begin
			tq_c = bmes_pkg::Q_MAX;
		end else begin
			tq_c = {1'b0, dq_s[T_TAN-1]};
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			dr_s[T_DPREP]       <= as_c >> 15;
			dq_s[T_DPREP]       <= {as_c[14:0], 16'h0};
			dd_s[T_DPREP]       <= ac_c;
			df_s[T_DPREP].szero <= (sin_dl == '0);
			df_s[T_DPREP].czero <= (ac_c == '0);
			df_s[T_DPREP].sat   <= (47'(as_c) >= {ac_c, 15'h0});
			df_s[T_DPREP].neg   <= sin_dl[31] ^ cos_dl[31];
			df_s[T_DPREP].ssign <= sin_dl[31];

			for (int k = T_DPREP + 1; k <= T_TAN - 1; k++) begin
				if ({dr_s[k-1], dq_s[k-1][30]} >= {1'b0, dd_s[k-1]}) begin
					dr_s[k] <= 32'({dr_s[k-1], dq_s[k-1][30]} - {1'b0, dd_s[k-1]});
					dq_s[k] <= {dq_s[k-1][29:0], 1'b1};
				end else begin
					dr_s[k] <= {dr_s[k-1][30:0], dq_s[k-1][30]};
					dq_s[k] <= {dq_s[k-1][29:0], 1'b0};
				end
				dd_s[k] <= dd_s[k-1];
				df_s[k] <= df_s[k-1];
			end

			if (df_s[T_TAN-1].szero) begin
				tan_s <= '0;
			end else if (df_s[T_TAN-1].czero) begin
				tan_s <= df_s[T_TAN-1].ssign ? -bmes_pkg::Q_MAX : bmes_pkg::Q_MAX;
			end else begin
				tan_s <= df_s[T_TAN-1].neg ? 32'(-tq_c) : tq_c;
			end
		end
	end

	// Yaw rate, new heading, and the move forward again from the rear axle.
	logic signed [63:0] wp_s, thp_s, hc_s, hs_s;
	logic signed [31:0] w_s, xn_s, yn_s;

	always_ff @(posedge clk) begin
		if (en) begin
			wp_s  <= 64'(vi_s[T_TAN]) * 64'(tan_s);
			w_s   <= bmes_pkg::qround(wp_s, 16);
			thp_s <= 64'(ts_sx) * 64'(w_s);
			thn_s[T_THN] <= bmes_pkg::sat32(64'(th_s[T_THN-1]) +
				64'(bmes_pkg::qround(thp_s, 16)));
			for (int k = T_THN + 1; k <= T_OUT; k++) begin
				thn_s[k] <= thn_s[k-1];
			end

			hc_s <= 64'(hwb_sx) * 64'(cos_tn);
			hs_s <= 64'(hwb_sx) * 64'(sin_tn);
			xn_s <= bmes_pkg::sat32(64'(xrn_s[T_FP]) + 64'(bmes_pkg::qround(hc_s, 30)));
			yn_s <= bmes_pkg::sat32(64'(yrn_s[T_FP]) + 64'(bmes_pkg::qround(hs_s, 30)));
		end
	end

	assign state_out.valid            = vld_s[T_OUT];
	assign state_out.next_pos_x       = xn_s;
	assign state_out.next_pos_y       = yn_s;
	assign state_out.next_steer_angle = dn_s[T_OUT];
	assign state_out.next_speed       = vn_s[T_OUT];
	assign state_out.next_heading     = thn_s[T_OUT];

	// A frozen pipeline must keep every valid bit where it was.
	a_freeze: assert property (@(posedge clk) disable iff (!arst_n)
		!en |=> $stable(vld_s))
		else $error("pipeline valid bits moved during a stall");

	// An accepted word shows up in the first stage.
	a_enter: assert property (@(posedge clk) disable iff (!arst_n)
		(state_in.valid && en) |=> vld_s[1])
		else $error("accepted word missing from first stage");

	// A word in the last internal stage reaches the output when the pipe moves.
	a_reach: assert property (@(posedge clk) disable iff (!arst_n)
		(en && vld_s[T_OUT-1]) |=> state_out.valid)
		else $error("word lost before the output register");
endmodule
